FILE: src/ber_tlv_stream_decoder_core_assert.svh
// Assertion macros for the BER TLV stream decoder.
`ifndef BER_TLV_STREAM_DECODER_CORE_ASSERT_SVH
`define BER_TLV_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on clk, held off while rst is high.
`define BTLV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on clk, also during reset.
`define BTLV_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BTLV_ASSERT(name, prop, msg)
`define BTLV_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

FILE: src/btlv_pkg.sv
// Shared types and constants for the BER TLV stream decoder.
package btlv_pkg;

  localparam int unsigned BTLV_MAX_LENGTH_BYTES = 4;

  localparam logic [7:0] TAG_BOOLEAN     = 8'h01;
  localparam logic [7:0] TAG_INTEGER     = 8'h02;
  localparam logic [7:0] TAG_ENUMERATED  = 8'h0A;
  localparam int unsigned TAG_CONSTRUCTED_BIT = 5;

  localparam logic [31:0] INT_MAX_BYTES  = 32'd4;
  localparam logic [31:0] BOOL_MAX_BYTES = 32'd1;

  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_LENOCT  = 5'b00100,
    PH_CONTENT = 5'b01000,
    PH_SKIP    = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_INT_LONG  = 3'd1,
    ERR_BOOL_LONG = 3'd2,
    ERR_TRUNC     = 3'd3,
    ERR_LEN_LONG  = 3'd4
  } err_code_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic        header_valid;
    logic [7:0]  tag_value;
    logic [31:0] content_length;
    logic        value_valid;
    logic [7:0]  value_byte;
    logic        element_done;
    logic [31:0] element_value;
    err_code_t   error_code;
    logic        message_end;
  } out_item_t;

  // Decoder state, less the length octet counter (its width follows the parameter).
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  current_tag;
    logic [31:0] length_acc;
    logic [31:0] bytes_left;
    logic [31:0] value_acc;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RESET = '{
    phase:       PH_TAG,
    current_tag: 8'h00,
    length_acc:  32'h0,
    bytes_left:  32'h0,
    value_acc:   32'h0
  };

endpackage

FILE: src/btlv_step.sv
// Per-byte decode step: next state and result for one input byte.
module btlv_step #(
  parameter int unsigned MAX_LENGTH_BYTES = btlv_pkg::BTLV_MAX_LENGTH_BYTES,
  localparam int unsigned OctW = $clog2(MAX_LENGTH_BYTES + 1)
) (
  input  btlv_pkg::in_item_t   item,
  input  btlv_pkg::dec_state_t cur,
  input  logic [OctW-1:0]      octets_left,
  output btlv_pkg::dec_state_t nxt,
  output logic [OctW-1:0]      octets_left_next,
  output btlv_pkg::out_item_t  res
);
  import btlv_pkg::*;

  logic [7:0]  b;
  logic        hdr_done;
  logic        numeric;
  logic [31:0] acc_new;
  err_code_t   err;

  assign b = item.data_byte;
  assign numeric = (cur.current_tag == TAG_INTEGER) || (cur.current_tag == TAG_ENUMERATED)
                || (cur.current_tag == TAG_BOOLEAN);
  assign acc_new = {cur.value_acc[23:0], b};

  always_comb begin
    nxt              = cur;
    octets_left_next = octets_left;
    res              = '0;
    err              = ERR_NONE;
    hdr_done         = 1'b0;

    case (cur.phase)
      PH_TAG: begin
        nxt.current_tag = b;
        nxt.length_acc  = '0;
        nxt.phase       = PH_LEN;
      end
      PH_LEN: begin
        if (!b[7]) begin
          nxt.length_acc = {24'h0, b};
          hdr_done       = 1'b1;
        end else if (b[6:0] > 7'(MAX_LENGTH_BYTES)) begin
          err = ERR_LEN_LONG;
        end else if (b[6:0] == 7'd0) begin
          // indefinite form taken as zero length
          nxt.length_acc = '0;
          hdr_done       = 1'b1;
        end else begin
          nxt.length_acc   = '0;
          octets_left_next = OctW'(b[6:0]);
          nxt.phase        = PH_LENOCT;
        end
      end
      PH_LENOCT: begin
        if (cur.length_acc[31:24] != 8'h00) begin
          err = ERR_LEN_LONG;
        end else begin
          nxt.length_acc   = {cur.length_acc[23:0], b};
          octets_left_next = octets_left - OctW'(1);
          hdr_done         = (octets_left == OctW'(1));
        end
      end
      PH_CONTENT: begin
        res.value_valid = 1'b1;
        res.value_byte  = b;
        if (numeric) begin
          nxt.value_acc = acc_new;
        end
        nxt.bytes_left = cur.bytes_left - 32'd1;
        if (cur.bytes_left == 32'd1) begin
          res.element_done = 1'b1;
          if (cur.current_tag == TAG_BOOLEAN) begin
            res.element_value = {31'h0, (acc_new != 32'h0)};
          end else if (numeric) begin
            res.element_value = acc_new;
          end
          nxt.phase = PH_TAG;
        end
      end
      PH_SKIP: begin
      end
      default: begin
        nxt.phase = PH_SKIP;
      end
    endcase

    if (hdr_done) begin
      res.header_valid = 1'b1;
      if (cur.current_tag[TAG_CONSTRUCTED_BIT]) begin
        nxt.phase = PH_TAG;
      end else if (((cur.current_tag == TAG_INTEGER) || (cur.current_tag == TAG_ENUMERATED))
                   && (nxt.length_acc > INT_MAX_BYTES)) begin
        err = ERR_INT_LONG;
      end else if ((cur.current_tag == TAG_BOOLEAN) && (nxt.length_acc > BOOL_MAX_BYTES)) begin
        err = ERR_BOOL_LONG;
      end else begin
        nxt.value_acc = '0;
        if (nxt.length_acc == 32'h0) begin
          res.element_done = 1'b1;
          nxt.phase        = PH_TAG;
        end else begin
          nxt.bytes_left = nxt.length_acc;
          nxt.phase      = PH_CONTENT;
        end
      end
    end

    if (err != ERR_NONE) begin
      nxt.phase = PH_SKIP;
    end else if (item.end_of_message && (cur.phase != PH_SKIP) && (nxt.phase != PH_TAG)) begin
      err = ERR_TRUNC;
    end

    res.tag_value      = nxt.current_tag;
    res.content_length = nxt.length_acc;
    res.error_code     = err;
    res.message_end    = item.end_of_message;

    // message end: decode state and octet counter back to their reset values
    if (item.end_of_message) begin
      nxt              = DEC_STATE_RESET;
      octets_left_next = '0;
    end
  end

endmodule

FILE: src/btlv_out_reg.sv
// Result register with valid/stall handshake toward the receiver.
module btlv_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  btlv_pkg::out_item_t load_data,
  output logic                full_blocked,
  output logic                out_valid,
  input  logic                out_stall,
  output btlv_pkg::out_item_t out_data
);
  import btlv_pkg::*;

  // Blocked only while a held result is not being taken.
  assign full_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

FILE: src/ber_tlv_stream_decoder_core.sv
// Top level of the BER TLV stream decoder.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one message byte per
//   transfer plus an end-of-message flag on the last byte. Output channel
//   (out_valid / out_stall / out_data) carries exactly one result per input
//   byte, in order: header, content byte, element completion and error info.
//   The result of an accepted byte is held in the output register until taken.
//   Throughput: one byte per cycle unless a held result is stalled, set by the
//   single decode step between the state registers and the result register.
//   in_stall rises only while a result sits in the output register and the
//   receiver stalls it; a held result is never overwritten. While it is being
//   taken the next byte is accepted in the same cycle.
//   Reset (rst, synchronous) empties the result register and puts the decoder
//   back to waiting for a tag. The end-of-message byte does the same to the
//   decode state once its result is formed.
//   After an error, bytes are consumed without flags until the message ends.
//   MAX_LENGTH_BYTES bounds the long-form length octet count (1..8).
module ber_tlv_stream_decoder_core #(
  parameter int unsigned MAX_LENGTH_BYTES = btlv_pkg::BTLV_MAX_LENGTH_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  btlv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output btlv_pkg::out_item_t out_data
);
  import btlv_pkg::*;

  localparam int unsigned OctW = $clog2(MAX_LENGTH_BYTES + 1);

  // decode state
  dec_state_t      state;
  dec_state_t      state_next;
  logic [OctW-1:0] octets_left;
  logic [OctW-1:0] octets_left_next;

  out_item_t       step_res;
  logic            in_take;

  assign in_take = in_valid && !in_stall;

  btlv_step #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_step (
    .item             (in_data),
    .cur              (state),
    .octets_left      (octets_left),
    .nxt              (state_next),
    .octets_left_next (octets_left_next),
    .res              (step_res)
  );

  // state advances only on an accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= DEC_STATE_RESET;
      octets_left <= '0;
    end else if (in_take) begin
      state       <= state_next;
      octets_left <= octets_left_next;
    end
  end

  btlv_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (in_take),
    .load_data    (step_res),
    .full_blocked (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

`include "ber_tlv_stream_decoder_core_assert.svh"

  `BTLV_ASSERT(a_result_follows, in_take |=> out_valid, "accepted byte produced no result")
  `BTLV_ASSERT(a_stall_only_full, in_stall |-> out_valid, "input stalled with empty result reg")
  `BTLV_ASSERT(a_eom_resets, (in_take && in_data.end_of_message) |=> (state.phase == PH_TAG), "decoder not reset after message end")
  `BTLV_ASSERT(a_skip_holds, (in_take && !in_data.end_of_message && (state.phase == PH_SKIP)) |=> (state.phase == PH_SKIP), "left error skip before message end")
  `BTLV_ASSERT(a_hdr_not_content, out_valid |-> !(out_data.header_valid && out_data.value_valid), "header and content flagged together")
  `BTLV_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result valid after reset")

endmodule
